[hdl/tld_pkg.sv]
// shared types and constants for the truncated label distance block
`timescale 1ns / 1ps
`default_nettype none

package tld_pkg;

    localparam int COORD_W   = 16;
    localparam int INDEX_W   = 10;
    localparam int SCALE_W   = 16;
    localparam int COST_W    = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = DIFF_W + SCALE_W + 1;
    localparam int FRAC_SHIFT = 12;
    localparam int SCALED_W  = 21;
    localparam int SQ_W      = 2 * SCALED_W - 2;
    localparam int SUM_W     = SQ_W + 2;
    localparam int RAD_SHIFT = 16;
    localparam int RAD_W     = SUM_W + RAD_SHIFT;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 1;
    localparam int AXES      = 3;
    localparam int S_DATA_W  = 120;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_X   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_Y   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_Z   = 3'd4;

    localparam logic [1:0] MODE_POTTS   = 2'd0;
    localparam logic [1:0] MODE_EUCLID  = 2'd1;
    localparam logic [1:0] MODE_SQUARED = 2'd2;

    localparam logic [COST_W-1:0]  THRESHOLD_RESET = 32'd65536;
    localparam logic [SCALE_W-1:0] SCALE_RESET     = 16'd4096;

    typedef struct packed {
        logic valid;
        logic idx_eq;
    } side_t;

endpackage

`default_nettype wire

[hdl/tld_axis.sv]
// per-axis difference, scaling, squaring and sum of squares pipeline
`timescale 1ns / 1ps
`default_nettype none

module tld_axis (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   enable,
    input  wire tld_pkg::side_t                         side_in,
    input  wire logic signed [tld_pkg::COORD_W-1:0]     first_d  [tld_pkg::AXES],
    input  wire logic signed [tld_pkg::COORD_W-1:0]     second_d [tld_pkg::AXES],
    input  wire logic        [tld_pkg::SCALE_W-1:0]     scale    [tld_pkg::AXES],
    output tld_pkg::side_t                              side_out,
    output logic             [tld_pkg::SUM_W-1:0]       sum_out
);

    localparam int DIFF_W = tld_pkg::DIFF_W;
    localparam int PROD_W = tld_pkg::PROD_W;

    tld_pkg::side_t side1_reg, side2_reg, side3_reg, side4_reg;

    logic signed [tld_pkg::DIFF_W-1:0]   diff_reg   [tld_pkg::AXES];
    logic signed [tld_pkg::DIFF_W-1:0]   diff_next  [tld_pkg::AXES];
    logic signed [tld_pkg::SCALED_W-1:0] scaled_reg [tld_pkg::AXES];
    logic signed [tld_pkg::SCALED_W-1:0] scaled_next[tld_pkg::AXES];
    logic        [tld_pkg::SQ_W-1:0]     sq_reg     [tld_pkg::AXES];
    logic        [tld_pkg::SQ_W-1:0]     sq_next    [tld_pkg::AXES];
    logic        [tld_pkg::SUM_W-1:0]    sum_reg;
    logic        [tld_pkg::SUM_W-1:0]    sum_next;

    always_comb begin
        logic signed [tld_pkg::PROD_W-1:0]     prod;
        logic signed [2*tld_pkg::SCALED_W-1:0] sq;
        for (int a = 0; a < tld_pkg::AXES; a++) begin
            diff_next[a] = DIFF_W'(first_d[a]) - DIFF_W'(second_d[a]);
            prod = PROD_W'(diff_reg[a]) * $signed({1'b0, scale[a]});
            // arithmetic shift gives the floor
            scaled_next[a] = prod[tld_pkg::FRAC_SHIFT +: tld_pkg::SCALED_W];
            sq = scaled_reg[a] * scaled_reg[a];
            sq_next[a] = sq[tld_pkg::SQ_W-1:0];
        end
        sum_next = tld_pkg::SUM_W'(sq_reg[0]) + tld_pkg::SUM_W'(sq_reg[1])
                 + tld_pkg::SUM_W'(sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg <= '0;
            side2_reg <= '0;
            side3_reg <= '0;
            side4_reg <= '0;
        end else if (enable) begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
            side4_reg <= side3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            diff_reg   <= diff_next;
            scaled_reg <= scaled_next;
            sq_reg     <= sq_next;
            sum_reg    <= sum_next;
        end
    end

    assign side_out = side4_reg;
    assign sum_out  = sum_reg;

endmodule

`default_nettype wire

[hdl/tld_sqrt.sv]
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none

module tld_sqrt (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              enable,
    input  wire tld_pkg::side_t                    side_in,
    input  wire logic [tld_pkg::SUM_W-1:0]         sum_in,
    output tld_pkg::side_t                         side_out,
    output logic      [tld_pkg::SUM_W-1:0]         sum_out,
    output logic      [tld_pkg::ROOT_W-1:0]        root_out
);

    localparam int N     = tld_pkg::ROOT_W;
    localparam int REM_W = tld_pkg::REM_W;
    localparam int RAD_W = tld_pkg::RAD_W;
    localparam int SUM_W = tld_pkg::SUM_W;

    tld_pkg::side_t   side_reg [N];
    logic [REM_W-1:0] rem_reg  [N];
    logic [N-1:0]     root_reg [N];
    logic [RAD_W-1:0] rad_reg  [N];
    logic [SUM_W-1:0] sum_reg  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        tld_pkg::side_t   side_in_k;
        logic [REM_W-1:0] rem_in;
        logic [N-1:0]     root_in;
        logic [RAD_W-1:0] rad_in;
        logic [SUM_W-1:0] sum_in_k;
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] rem_sub;
        logic             ge;
        logic [REM_W-1:0] rem_next;
        logic [N-1:0]     root_next;
        logic [RAD_W-1:0] rad_next;

        if (k == 0) begin : g_first
            assign side_in_k = side_in;
            assign rem_in    = '0;
            assign root_in   = '0;
            assign rad_in    = {sum_in, {tld_pkg::RAD_SHIFT{1'b0}}};
            assign sum_in_k  = sum_in;
        end else begin : g_next
            assign side_in_k = side_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign root_in   = root_reg[k-1];
            assign rad_in    = rad_reg[k-1];
            assign sum_in_k  = sum_reg[k-1];
        end

        always_comb begin
            rem_sh    = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial     = {1'b0, root_in, 2'b01};
            ge        = rem_sh >= trial;
            rem_sub   = rem_sh - trial;
            rem_next  = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_next = {root_in[N-2:0], ge};
            rad_next  = {rad_in[RAD_W-3:0], 2'b00};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[k] <= '0;
            end else if (enable) begin
                side_reg[k] <= side_in_k;
            end
        end

        always_ff @(posedge aclk) begin
            if (enable) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_next;
                sum_reg[k]  <= sum_in_k;
            end
        end
    end

    assign side_out = side_reg[N-1];
    assign sum_out  = sum_reg[N-1];
    assign root_out = root_reg[N-1];

endmodule

`default_nettype wire

[hdl/truncated_label_distance_top.sv]
// top level: stream ports, configuration registers, cost select and output register
`timescale 1ns / 1ps
`default_nettype none

// Pairwise label cost for a 3-D displacement MRF. One pair transfer can be taken
// every clock and each gives one cost transfer after passing the axis difference,
// scaling, squaring and summing registers, the square root stages (one root bit
// per stage) and the output register. When m_tready is low with a result
// waiting, the whole pipeline holds and s_tready drops. Configuration registers
// may be written only while no pair is in flight.
module truncated_label_distance_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // first_index, second_index, first_dx, first_dy, first_dz,
    // second_dx, second_dy, second_dz, zero pad
    input  wire logic [tld_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // cost
    output logic      [tld_pkg::COST_W-1:0]          m_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tld_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [tld_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int CW = tld_pkg::COORD_W;
    localparam int IW = tld_pkg::INDEX_W;

    logic [1:0]                  mode_reg;
    logic [tld_pkg::COST_W-1:0]  threshold_reg;
    logic [tld_pkg::SCALE_W-1:0] scale_reg [tld_pkg::AXES];

    logic                        enable;
    tld_pkg::side_t              side_in;
    logic signed [CW-1:0]        first_d  [tld_pkg::AXES];
    logic signed [CW-1:0]        second_d [tld_pkg::AXES];
    tld_pkg::side_t              axis_side;
    logic [tld_pkg::SUM_W-1:0]   axis_sum;
    tld_pkg::side_t              root_side;
    logic [tld_pkg::SUM_W-1:0]   root_sum;
    logic [tld_pkg::ROOT_W-1:0]  root;

    logic                        m_tvalid_reg;
    logic [tld_pkg::COST_W-1:0]  cost_reg;
    logic [tld_pkg::COST_W-1:0]  cost_next;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= tld_pkg::MODE_EUCLID;
            threshold_reg <= tld_pkg::THRESHOLD_RESET;
            scale_reg[0]  <= tld_pkg::SCALE_RESET;
            scale_reg[1]  <= tld_pkg::SCALE_RESET;
            scale_reg[2]  <= tld_pkg::SCALE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tld_pkg::CFG_MODE:      mode_reg      <= cfg_wr_data[1:0];
                tld_pkg::CFG_THRESHOLD: threshold_reg <= cfg_wr_data;
                tld_pkg::CFG_SCALE_X:   scale_reg[0]  <= cfg_wr_data[tld_pkg::SCALE_W-1:0];
                tld_pkg::CFG_SCALE_Y:   scale_reg[1]  <= cfg_wr_data[tld_pkg::SCALE_W-1:0];
                tld_pkg::CFG_SCALE_Z:   scale_reg[2]  <= cfg_wr_data[tld_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign enable   = !m_tvalid_reg || m_tready;
    assign s_tready = enable;

    assign side_in.valid  = s_tvalid;
    assign side_in.idx_eq = s_tdata[IW-1:0] == s_tdata[2*IW-1:IW];

    for (genvar a = 0; a < tld_pkg::AXES; a++) begin : g_unpack
        assign first_d[a]  = s_tdata[2*IW + a*CW +: CW];
        assign second_d[a] = s_tdata[2*IW + (a+tld_pkg::AXES)*CW +: CW];
    end

    tld_axis u_axis (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .enable   (enable),
        .side_in  (side_in),
        .first_d  (first_d),
        .second_d (second_d),
        .scale    (scale_reg),
        .side_out (axis_side),
        .sum_out  (axis_sum)
    );

    tld_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .enable   (enable),
        .side_in  (axis_side),
        .sum_in   (axis_sum),
        .side_out (root_side),
        .sum_out  (root_sum),
        .root_out (root)
    );

    always_comb begin
        unique case (mode_reg)
            tld_pkg::MODE_POTTS:
                cost_next = root_side.idx_eq ? '0 : threshold_reg;
            tld_pkg::MODE_EUCLID:
                cost_next = (tld_pkg::COST_W'(root) > threshold_reg)
                          ? threshold_reg : tld_pkg::COST_W'(root);
            tld_pkg::MODE_SQUARED:
                cost_next = (root_sum > tld_pkg::SUM_W'(threshold_reg))
                          ? threshold_reg : root_sum[tld_pkg::COST_W-1:0];
            default:
                cost_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (enable) begin
            m_tvalid_reg <= root_side.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            cost_reg <= cost_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = cost_reg;

endmodule

`default_nettype wire

[bench/tb_truncated_label_distance_top.sv]
// testbench for truncated_label_distance_top: directed and random pairs against a predictor
`timescale 1ns / 1ps

module tb_truncated_label_distance_top;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_PAIRS    = 145;
    localparam int PRESSURE_PAIRS = 120;

    typedef struct packed {
        logic [tld_pkg::COORD_W-1:0] second_dz;
        logic [tld_pkg::COORD_W-1:0] second_dy;
        logic [tld_pkg::COORD_W-1:0] second_dx;
        logic [tld_pkg::COORD_W-1:0] first_dz;
        logic [tld_pkg::COORD_W-1:0] first_dy;
        logic [tld_pkg::COORD_W-1:0] first_dx;
        logic [tld_pkg::INDEX_W-1:0] second_index;
        logic [tld_pkg::INDEX_W-1:0] first_index;
    } label_pair_t;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_style_t;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    // first_index, second_index, first_dx, first_dy, first_dz,
    // second_dx, second_dy, second_dz, zero pad
    logic [tld_pkg::S_DATA_W-1:0]    s_tdata     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    // cost
    logic [tld_pkg::COST_W-1:0]      m_tdata;
    logic                            cfg_wr_en   = 1'b0;
    logic [tld_pkg::CFG_INDEX_W-1:0] cfg_index   = tld_pkg::CFG_MODE;
    logic [tld_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;

    // local copy of the configuration registers
    logic [1:0]                  cost_mode      = tld_pkg::MODE_EUCLID;
    logic [tld_pkg::COST_W-1:0]  cost_threshold = tld_pkg::THRESHOLD_RESET;
    logic [tld_pkg::SCALE_W-1:0] axis_scale_x   = tld_pkg::SCALE_RESET;
    logic [tld_pkg::SCALE_W-1:0] axis_scale_y   = tld_pkg::SCALE_RESET;
    logic [tld_pkg::SCALE_W-1:0] axis_scale_z   = tld_pkg::SCALE_RESET;

    logic [tld_pkg::COST_W-1:0]  pending_costs[$];
    logic [tld_pkg::COST_W-1:0]  expected_cost;
    int                          error_count   = 0;
    int                          idle_cycles   = 0;
    int                          burst_left    = 0;
    bit                          steady_flow   = 1'b0;
    logic                        hold_active   = 1'b0;
    ready_style_t                ready_style   = READY_ALWAYS;
    int                          style_left    = 0;
    logic [3:0]                  ready_tick    = '0;
    event                        hold_start;

    truncated_label_distance_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint floor_sqrt(input longint radicand);
        longint root;
        longint trial;
        root = 0;
        for (int b = 29; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic logic [tld_pkg::COST_W-1:0] predict_cost(input label_pair_t p);
        logic [tld_pkg::COORD_W-1:0] first_axis [tld_pkg::AXES];
        logic [tld_pkg::COORD_W-1:0] second_axis [tld_pkg::AXES];
        logic [tld_pkg::SCALE_W-1:0] scales [tld_pkg::AXES];
        longint scaled;
        longint sq_sum;
        longint full_cost;
        first_axis  = '{p.first_dx, p.first_dy, p.first_dz};
        second_axis = '{p.second_dx, p.second_dy, p.second_dz};
        scales      = '{axis_scale_x, axis_scale_y, axis_scale_z};
        sq_sum = 0;
        case (cost_mode)
            tld_pkg::MODE_POTTS: begin
                return (p.first_index == p.second_index) ? '0 : cost_threshold;
            end
            tld_pkg::MODE_EUCLID, tld_pkg::MODE_SQUARED: begin
                for (int a = 0; a < tld_pkg::AXES; a++) begin
                    // arithmetic shift floors toward minus infinity
                    scaled = ((longint'($signed(first_axis[a]))
                             - longint'($signed(second_axis[a])))
                             * longint'(scales[a])) >>> tld_pkg::FRAC_SHIFT;
                    sq_sum += scaled * scaled;
                end
                full_cost = (cost_mode == tld_pkg::MODE_EUCLID)
                          ? floor_sqrt(sq_sum << tld_pkg::RAD_SHIFT) : sq_sum;
                if (full_cost > longint'(cost_threshold)) begin
                    return cost_threshold;
                end
                return full_cost[tld_pkg::COST_W-1:0];
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    function automatic label_pair_t pair_of(input int fi, input int si,
                                            input int fx, input int fy, input int fz,
                                            input int sx, input int sy, input int sz);
        label_pair_t p;
        p.first_index  = tld_pkg::INDEX_W'(fi);
        p.second_index = tld_pkg::INDEX_W'(si);
        p.first_dx     = tld_pkg::COORD_W'(fx);
        p.first_dy     = tld_pkg::COORD_W'(fy);
        p.first_dz     = tld_pkg::COORD_W'(fz);
        p.second_dx    = tld_pkg::COORD_W'(sx);
        p.second_dy    = tld_pkg::COORD_W'(sy);
        p.second_dz    = tld_pkg::COORD_W'(sz);
        return p;
    endfunction

    function automatic logic [tld_pkg::COORD_W-1:0] corner_coord();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic label_pair_t random_pair();
        label_pair_t p;
        logic [127:0] noise;
        int kind;
        kind = $urandom_range(0, 9);
        noise = {$urandom, $urandom, $urandom, $urandom};
        p = noise[$bits(label_pair_t)-1:0];
        if ($urandom_range(0, 9) < 3) begin
            p.second_index = p.first_index;
        end
        if (kind <= 3) begin
            // neighboring labels: small displacement differences
            p.second_dx = p.first_dx + tld_pkg::COORD_W'($urandom_range(0, 1200) - 600);
            p.second_dy = p.first_dy + tld_pkg::COORD_W'($urandom_range(0, 1200) - 600);
            p.second_dz = p.first_dz + tld_pkg::COORD_W'($urandom_range(0, 1200) - 600);
        end else if (kind <= 6) begin
            // fully random fields
        end else if (kind <= 8) begin
            p.first_dx  = corner_coord();
            p.first_dy  = corner_coord();
            p.first_dz  = corner_coord();
            p.second_dx = corner_coord();
            p.second_dy = corner_coord();
            p.second_dz = corner_coord();
        end else begin
            p.second_dx = p.first_dx;
            p.second_dy = p.first_dy;
            p.second_dz = p.first_dz;
        end
        return p;
    endfunction

    task automatic send_pair(input label_pair_t p);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(tld_pkg::S_DATA_W - $bits(label_pair_t)){1'b0}}, p};
        do @(posedge aclk); while (!s_tready);
        if (!steady_flow) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_costs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tld_pkg::CFG_INDEX_W-1:0] index,
                             input logic [tld_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= value;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [1:0] mode_value,
                             input logic [tld_pkg::COST_W-1:0] thr,
                             input logic [tld_pkg::SCALE_W-1:0] sx,
                             input logic [tld_pkg::SCALE_W-1:0] sy,
                             input logic [tld_pkg::SCALE_W-1:0] sz);
        wait_drained();
        write_reg(tld_pkg::CFG_MODE, tld_pkg::CFG_DATA_W'(mode_value));
        write_reg(tld_pkg::CFG_THRESHOLD, thr);
        write_reg(tld_pkg::CFG_SCALE_X, tld_pkg::CFG_DATA_W'(sx));
        write_reg(tld_pkg::CFG_SCALE_Y, tld_pkg::CFG_DATA_W'(sy));
        write_reg(tld_pkg::CFG_SCALE_Z, tld_pkg::CFG_DATA_W'(sz));
        cfg_wr_en <= 1'b0;
        cost_mode      = mode_value;
        cost_threshold = thr;
        axis_scale_x   = sx;
        axis_scale_y   = sy;
        axis_scale_z   = sz;
        @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pair_of(1, 2, 128, 0, 0, 0, 0, 0));
        send_pair(pair_of(3, 4, 256, -256, 0, 0, 0, 0));
    endtask

    task automatic test_potts();
        configure(tld_pkg::MODE_POTTS, 32'hFFFF_FFFF, tld_pkg::SCALE_RESET,
                  tld_pkg::SCALE_RESET, tld_pkg::SCALE_RESET);
        send_pair(pair_of(0, 0, 100, -100, 7, 3, 2, 1));
        send_pair(pair_of(1023, 1023, -32768, 32767, 0, 32767, -32768, 0));
        send_pair(pair_of(0, 1023, 0, 0, 0, 0, 0, 0));
        send_pair(pair_of(512, 513, 5, 5, 5, 5, 5, 5));
    endtask

    task automatic test_euclid_extremes();
        configure(tld_pkg::MODE_EUCLID, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pair(pair_of(1, 2, 32767, 32767, 32767, -32768, -32768, -32768));
        send_pair(pair_of(3, 4, -32768, -32768, -32768, 32767, 32767, 32767));
        send_pair(pair_of(5, 6, -1, 0, 1, 0, 0, 0));
        send_pair(pair_of(7, 7, 1234, -4321, 77, 1234, -4321, 77));
    endtask

    task automatic test_squared();
        configure(tld_pkg::MODE_SQUARED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pair(pair_of(1, 2, 32767, -32768, 32767, -32768, 32767, -32768));
        send_pair(pair_of(3, 4, 1, 1, 1, 0, 0, 0));
        configure(tld_pkg::MODE_SQUARED, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 16'h0001);
        send_pair(pair_of(5, 6, 32767, 300, -300, -32768, -300, 300));
        send_pair(pair_of(8, 9, -7, -9000, 4095, 7, 9000, -4095));
    endtask

    task automatic test_unused_mode();
        configure(MODE_UNUSED, 32'hFFFF_FFFF, tld_pkg::SCALE_RESET,
                  tld_pkg::SCALE_RESET, tld_pkg::SCALE_RESET);
        send_pair(pair_of(0, 1023, 32767, 32767, 32767, -32768, -32768, -32768));
        send_pair(pair_of(9, 9, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_zero_threshold();
        configure(tld_pkg::MODE_EUCLID, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pair(pair_of(1, 2, 32767, 32767, 32767, -32768, -32768, -32768));
        configure(tld_pkg::MODE_POTTS, '0, tld_pkg::SCALE_RESET,
                  tld_pkg::SCALE_RESET, tld_pkg::SCALE_RESET);
        send_pair(pair_of(1, 2, 0, 0, 0, 0, 0, 0));
        send_pair(pair_of(1023, 0, 0, 0, 0, 0, 0, 0));
    endtask

    function automatic logic [tld_pkg::SCALE_W-1:0] random_scale();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return tld_pkg::SCALE_RESET;
            3:       return tld_pkg::SCALE_W'($urandom_range(1024, 8192));
            default: return tld_pkg::SCALE_W'($urandom);
        endcase
    endfunction

    function automatic logic [tld_pkg::COST_W-1:0] random_threshold();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return tld_pkg::COST_W'($urandom);
            3:       return tld_pkg::COST_W'($urandom_range(0, 1 << 20));
            default: return tld_pkg::COST_W'($urandom_range(0, 1 << 27));
        endcase
    endfunction

    task automatic test_random_settings();
        logic [1:0] mode_value;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            mode_value = (phase == 7) ? MODE_UNUSED : 2'(phase % 3);
            if (phase < 3) begin
                configure(mode_value, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            end else begin
                configure(mode_value, random_threshold(), random_scale(), random_scale(),
                          random_scale());
            end
            steady_flow = (phase % 4 == 1);
            for (int n = 0; n < PHASE_PAIRS; n++) begin
                send_pair(random_pair());
            end
            steady_flow = 1'b0;
        end
    endtask

    task automatic test_output_stall();
        configure(tld_pkg::MODE_SQUARED, random_threshold(), random_scale(), random_scale(),
                  random_scale());
        steady_flow = 1'b1;
        -> hold_start;
        for (int n = 0; n < PRESSURE_PAIRS; n++) begin
            send_pair(random_pair());
        end
        steady_flow = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            pending_costs.push_back(
                predict_cost(label_pair_t'(s_tdata[$bits(label_pair_t)-1:0])));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_costs.size() == 0) begin
                error_count++;
                $display("%0t: unexpected cost transfer, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                expected_cost = pending_costs.pop_front();
                if (m_tdata !== expected_cost) begin
                    error_count++;
                    $display("%0t: cost mismatch, expected %h, actual %h",
                             $time, expected_cost, m_tdata);
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (style_left == 0) begin
            ready_style = ready_style_t'($urandom_range(0, 3));
            style_left  = $urandom_range(20, 200);
        end else begin
            style_left--;
        end
        ready_tick <= ready_tick + 1'b1;
        if (hold_active) begin
            m_tready <= 1'b0;
        end else begin
            case (ready_style)
                READY_ALWAYS:   m_tready <= 1'b1;
                READY_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
                READY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                default:        m_tready <= ready_tick[1];
            endcase
        end
    end

    // long receiver hold-off so the pipeline fills and stalls the input
    always begin
        @(hold_start);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("truncated_label_distance_top test failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_potts();
        test_euclid_extremes();
        test_squared();
        test_unused_mode();
        test_zero_threshold();
        test_random_settings();
        test_output_stall();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("truncated_label_distance_top test passed");
        end else begin
            $display("truncated_label_distance_top test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/tld_pkg.sv
hdl/tld_axis.sv
hdl/tld_sqrt.sv
hdl/truncated_label_distance_top.sv
bench/tb_truncated_label_distance_top.sv
